// ===== rtl/barometric_pressure_to_altitude_macros.svh =====
// Assertion macros for the barometric altitude block.
`ifndef BAROMETRIC_PRESSURE_TO_ALTITUDE_MACROS_SVH
`define BAROMETRIC_PRESSURE_TO_ALTITUDE_MACROS_SVH

// Same-cycle implication.
`define BPA_CHECK(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication after a fixed number of cycles.
`define BPA_CHECK_LAT(label, clk, rst_n, ante, lat, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##lat (cons)) \
		else $error(msg);

`endif

// ===== rtl/bpa_pkg.sv =====
// Shared types, widths and build-time layer tables for the barometric altitude block.
package bpa_pkg;

	localparam int ROM_LAYERS = 8;
	localparam int IDX_W = 3;
	localparam int P_W = 21;
	localparam int H_W = 22;
	localparam int FRAC = 28;
	localparam int XL_W = 30;
	localparam int ACC_W = 30;
	localparam int E_W = 5;
	localparam int LNV_W = 36;
	localparam int LNR_W = 32;
	localparam int R_W = 30;
	localparam int XE_W = 31;
	localparam int KQ_W = 27;
	localparam int COEF_W = 33;
	localparam int HS_W = 28;
	localparam int NUM_LAYERS_DEF = 7;
	localparam int CORDIC_STAGES_DEF = 24;

	typedef enum logic [1:0] {
		ST_IN_RANGE = 2'd0,
		ST_CLAMP_LO = 2'd1,
		ST_CLAMP_HI = 2'd2
	} status_t;

	typedef struct packed {
		logic                    valid;
		status_t                 status;
		logic [IDX_W-1:0]        layer;
		logic [E_W-1:0]          expo;
		logic signed [LNR_W-1:0] lnr;
	} side_t;

	typedef longint rom_t [ROM_LAYERS];

	typedef enum int {
		ROM_LN_PB,
		ROM_PB_INT,
		ROM_KQ_MAG,
		ROM_KQ_NEG,
		ROM_COEF_MAG,
		ROM_COEF_NEG
	} rom_sel_t;

	// base heights in m, lapse rates in 1e-4 K/m
	localparam rom_t BASE_M = '{-610, 11000, 20000, 32000, 47000, 51000, 71000, 84852};
	localparam rom_t LAPSE_E4 = '{-65, 0, 10, 28, 0, -28, -20, 0};

	localparam longint unsigned G_E5 = 64'd980665;
	localparam longint unsigned R_E5 = 64'd28705287;
	localparam longint unsigned TEN4 = 64'd10000;
	localparam longint EXP_LIMIT = 64'sd201326592;

	// restoring long division, fb extra fraction bits
	function automatic longint unsigned div_q(longint unsigned n, longint unsigned d, int fb);
		longint unsigned q;
		longint unsigned r;
		int i;
		q = 0;
		r = 0;
		if (d == 0) return 0;
		for (i = 63; i >= 0; i--) begin
			r = (r << 1) | ((n >> i) & 64'd1);
			q = q << 1;
			if (r >= d) begin
				r = r - d;
				q = q | 64'd1;
			end
		end
		for (i = 0; i < fb; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= d) begin
				r = r - d;
				q = q | 64'd1;
			end
		end
		return q;
	endfunction

	// ln(1+2^-i) in Q28 from an atanh series
	function automatic longint unsigned lntab_f(int i);
		longint unsigned u;
		longint unsigned u2;
		longint unsigned pw;
		longint unsigned s;
		int k;
		u = div_q(64'd1, (64'd1 << (i + 1)) + 64'd1, 31);
		u2 = (u * u) >> 31;
		pw = u;
		s = u;
		for (k = 1; k <= 12; k++) begin
			pw = (pw * u2) >> 31;
			s = s + div_q(pw, 64'(2 * k + 1), 0);
		end
		return (64'd2 * s + 64'd4) >> 3;
	endfunction

	localparam longint unsigned LN2Q = lntab_f(0);
	localparam longint unsigned TWO_Q = 64'd2 << FRAC;

	function automatic longint ln_fix_f(longint unsigned v, int stages);
		int e;
		int b;
		int i;
		longint unsigned vv;
		longint unsigned x;
		longint unsigned t;
		longint unsigned acc;
		vv = (v == 0) ? 64'd1 : v;
		e = 0;
		for (b = 1; b < 64; b++)
			if ((vv >> b) != 0) e = b;
		x = (e <= FRAC) ? (vv << (FRAC - e)) : (vv >> (e - FRAC));
		acc = 0;
		for (i = 1; i <= stages; i++) begin
			t = x + (x >> i);
			if (t < TWO_Q) begin
				x = t;
				acc = acc + lntab_f(i);
			end
		end
		return longint'(e) * $signed(LN2Q) + $signed(LN2Q) - $signed(acc)
			- $signed((TWO_Q - x) >> 1);
	endfunction

	function automatic longint unsigned exp_fix_f(longint y, int stages);
		longint yy;
		longint unsigned x;
		longint unsigned r;
		int i;
		yy = y;
		if (yy > EXP_LIMIT) yy = EXP_LIMIT;
		if (yy < -EXP_LIMIT) yy = -EXP_LIMIT;
		r = $unsigned(yy + 2 * $signed(LN2Q));
		x = 64'd1 << (FRAC - 2);
		for (i = 0; i < 2; i++)
			if (r >= LN2Q) begin
				r = r - LN2Q;
				x = x << 1;
			end
		for (i = 1; i <= stages; i++)
			if (r >= lntab_f(i)) begin
				r = r - lntab_f(i);
				x = x + (x >> i);
			end
		return x + ((x * r) >> FRAC);
	endfunction

	function automatic longint smul_f(longint a, longint b, int sh);
		longint unsigned ma;
		longint unsigned mb;
		longint unsigned p;
		ma = (a < 0) ? $unsigned(-a) : $unsigned(a);
		mb = (b < 0) ? $unsigned(-b) : $unsigned(b);
		p = ma * mb;
		p = (p + (64'd1 << (sh - 1))) >> sh;
		return ((a < 0) != (b < 0)) ? -$signed(p) : $signed(p);
	endfunction

	// layer recursion; returns the table picked by sel
	function automatic rom_t build_rom(int stages, rom_sel_t sel);
		longint temp [ROM_LAYERS];
		longint ln_pb [ROM_LAYERS];
		longint kq [ROM_LAYERS];
		longint coef [ROM_LAYERS];
		longint unsigned pb [ROM_LAYERS];
		rom_t res;
		int i;
		longint l;
		longint dh;
		longint dlt;
		longint e;
		longint n;
		longint km;
		longint dm;
		longint unsigned ml;
		longint unsigned x;
		temp[0] = 2921500;
		ln_pb[0] = ln_fix_f(64'd1089000, stages);
		pb[0] = 64'd1089000;
		for (i = 1; i < ROM_LAYERS; i++) begin
			l = LAPSE_E4[i-1];
			ml = (l < 0) ? $unsigned(-l) : $unsigned(l);
			dh = BASE_M[i] - BASE_M[i-1];
			if (dh < 0) dh = 0;
			temp[i] = temp[i-1] + l * dh;
			if (temp[i] < 1) temp[i] = 1;
			if (l != 0) begin
				dlt = ln_fix_f($unsigned(temp[i-1]), stages) - ln_fix_f($unsigned(temp[i]), stages);
				e = $signed(div_q(G_E5 * TEN4, R_E5 * ml, 20));
				if (l < 0) e = -e;
				ln_pb[i] = ln_pb[i-1] + smul_f(e, dlt, 20);
			end else begin
				ln_pb[i] = ln_pb[i-1] - $signed(div_q(G_E5 * TEN4 * $unsigned(dh),
					R_E5 * $unsigned(temp[i-1]), 28));
			end
			if (ln_pb[i] < 0) ln_pb[i] = 0;
			n = $signed(div_q($unsigned(ln_pb[i]), LN2Q, 0));
			if (n > 30) n = 30;
			x = exp_fix_f(ln_pb[i] - n * $signed(LN2Q), stages);
			pb[i] = ((x << n) + (64'd1 << (FRAC - 1))) >> FRAC;
		end
		for (i = 0; i < ROM_LAYERS; i++) begin
			l = LAPSE_E4[i];
			ml = (l < 0) ? $unsigned(-l) : $unsigned(l);
			if (l != 0) begin
				km = $signed(div_q(R_E5 * ml, G_E5 * TEN4, 28));
				dm = $signed(div_q($unsigned(temp[i]) * 64'd16, ml, 10));
				kq[i] = (l < 0) ? km : -km;
				coef[i] = (l < 0) ? -dm : dm;
			end else begin
				kq[i] = 0;
				coef[i] = $signed(div_q(R_E5 * $unsigned(temp[i]) * 64'd16, G_E5 * TEN4, 10));
			end
		end
		for (i = 0; i < ROM_LAYERS; i++) begin
			unique case (sel)
				ROM_LN_PB:    res[i] = ln_pb[i];
				ROM_PB_INT:   res[i] = $signed(pb[i]);
				ROM_KQ_MAG:   res[i] = (kq[i] < 0) ? -kq[i] : kq[i];
				ROM_KQ_NEG:   res[i] = (kq[i] < 0) ? 1 : 0;
				ROM_COEF_MAG: res[i] = (coef[i] < 0) ? -coef[i] : coef[i];
				ROM_COEF_NEG: res[i] = (coef[i] < 0) ? 1 : 0;
				default:      res[i] = 0;
			endcase
		end
		return res;
	endfunction

endpackage

// ===== rtl/bpa_ln_cell.sv =====
// Log chain cell: one multiplicative normalization step toward 2.0.
module bpa_ln_cell #(
	parameter int SHIFT = 1,
	parameter logic [bpa_pkg::ACC_W-1:0] LNK = '0
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bpa_pkg::side_t             side_in,
	input  logic [bpa_pkg::XL_W-1:0]   x_in,
	input  logic [bpa_pkg::ACC_W-1:0]  acc_in,
	output bpa_pkg::side_t             side_out,
	output logic [bpa_pkg::XL_W-1:0]   x_out,
	output logic [bpa_pkg::ACC_W-1:0]  acc_out
);
	import bpa_pkg::*;

	logic [XL_W:0] t;
	logic          take;
	side_t         side_q;
	logic [XL_W-1:0]  x_q;
	logic [ACC_W-1:0] acc_q;

	assign t = {1'b0, x_in} + {1'b0, x_in >> SHIFT};
	assign take = t < (XL_W+1)'(TWO_Q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= '0;
		end else begin
			side_q <= side_in;
		end
	end

	always_ff @(posedge clk) begin
		x_q <= take ? t[XL_W-1:0] : x_in;
		acc_q <= take ? acc_in + LNK : acc_in;
	end

	assign side_out = side_q;
	assign x_out = x_q;
	assign acc_out = acc_q;

endmodule

// ===== rtl/bpa_exp_cell.sv =====
// Exp chain cell: subtract one log constant, scale x to match.
module bpa_exp_cell #(
	parameter int SHIFT = 1,
	parameter logic [bpa_pkg::R_W-1:0] LNK = '0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bpa_pkg::side_t            side_in,
	input  logic [bpa_pkg::XE_W-1:0]  x_in,
	input  logic [bpa_pkg::R_W-1:0]   r_in,
	output bpa_pkg::side_t            side_out,
	output logic [bpa_pkg::XE_W-1:0]  x_out,
	output logic [bpa_pkg::R_W-1:0]   r_out
);
	import bpa_pkg::*;

	logic            take;
	side_t           side_q;
	logic [XE_W-1:0] x_q;
	logic [R_W-1:0]  r_q;

	assign take = r_in >= LNK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= '0;
		end else begin
			side_q <= side_in;
		end
	end

	// shift of zero doubles x
	always_ff @(posedge clk) begin
		x_q <= take ? x_in + (x_in >> SHIFT) : x_in;
		r_q <= take ? r_in - LNK : r_in;
	end

	assign side_out = side_q;
	assign x_out = x_q;
	assign r_out = r_q;

endmodule

// ===== rtl/barometric_pressure_to_altitude.sv =====
// Top level: pressure sample to standard-atmosphere geopotential height.
//
// Takes one 21-bit pressure sample (0.1 Pa) per beat on start and, when the
// sample leaves the pipeline, pulses done for one cycle with the height in
// signed 1/16 m and a range status (in range, clamped to the bottom base
// height, clamped to the top base height). A new sample may be started every
// cycle; busy is always low. The pipeline is made of two rows of cells:
// CORDIC_STAGES log cells and CORDIC_STAGES+2 exp cells, plus eleven
// registers for capture, layer select, normalization, the log finish, the
// log ratio, the two multiplies, rounding, the residual product, the
// multiplicand pick and the output. done cannot be held off, so the receiver
// must capture every result in the cycle it is shown. The layer base
// pressures, their logs and the per-layer coefficients are built into
// constant tables at elaboration from the layer recursion.
`include "barometric_pressure_to_altitude_macros.svh"

module barometric_pressure_to_altitude #(
	parameter int NUM_LAYERS = bpa_pkg::NUM_LAYERS_DEF,
	parameter int CORDIC_STAGES = bpa_pkg::CORDIC_STAGES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [bpa_pkg::P_W-1:0]          pressure,
	output logic                             done,
	output logic signed [bpa_pkg::H_W-1:0]   altitude,
	output logic [1:0]                       range_status
);
	import bpa_pkg::*;

	localparam int TOP = NUM_LAYERS - 1;
	localparam int LAT = 2 * CORDIC_STAGES + 13;
	localparam int PK_W = KQ_W + LNR_W - 1;
	localparam int PC_W = COEF_W + LNR_W - 1;
	localparam int XR_W = XE_W + R_W;

	// build-time tables
	localparam rom_t LN_PB = build_rom(CORDIC_STAGES, ROM_LN_PB);
	localparam rom_t PB_INT = build_rom(CORDIC_STAGES, ROM_PB_INT);
	localparam rom_t KQ_MAG = build_rom(CORDIC_STAGES, ROM_KQ_MAG);
	localparam rom_t KQ_NEG = build_rom(CORDIC_STAGES, ROM_KQ_NEG);
	localparam rom_t COEF_MAG = build_rom(CORDIC_STAGES, ROM_COEF_MAG);
	localparam rom_t COEF_NEG = build_rom(CORDIC_STAGES, ROM_COEF_NEG);

	localparam logic signed [HS_W-1:0] LO_H = HS_W'(BASE_M[0] * 16);
	localparam logic signed [HS_W-1:0] HI_H = HS_W'(BASE_M[TOP] * 16);
	localparam logic [R_W-1:0] EXP_LIM_R = R_W'(EXP_LIMIT);
	localparam logic [R_W-1:0] TWO_LN2 = R_W'(2 * LN2Q);

	assign busy = 1'b0;

	// ---- stage 1: capture the sample
	logic           valid_s1;
	logic [P_W-1:0] p_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		p_s1 <= pressure;
	end

	// ---- stage 2: range check, layer select by parallel compare, leading one
	side_t          side_c2;
	side_t          side_s2;
	logic [P_W-1:0] p_s2;

	always_comb begin
		side_c2 = '0;
		side_c2.valid = valid_s1;
		if (p_s1 > P_W'(PB_INT[0])) begin
			side_c2.status = ST_CLAMP_LO;
		end else if (p_s1 < P_W'(PB_INT[TOP])) begin
			side_c2.status = ST_CLAMP_HI;
		end else begin
			side_c2.status = ST_IN_RANGE;
		end
		// bases fall with height, so the layer is the count of bases above p
		for (int i = 1; i < ROM_LAYERS; i++)
			if (i <= TOP && P_W'(PB_INT[i]) > p_s1)
				side_c2.layer = side_c2.layer + IDX_W'(1);
		for (int b = 0; b < P_W; b++)
			if (p_s1[b])
				side_c2.expo = E_W'(b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s2 <= '0;
		end else begin
			side_s2 <= side_c2;
		end
	end

	always_ff @(posedge clk) begin
		p_s2 <= p_s1;
	end

	// ---- stage 3: normalize mantissa into [1,2) Q28; zero reads as one
	logic [P_W-1:0]  pv;
	side_t           side_s3;
	logic [XL_W-1:0] x_s3;

	assign pv = (p_s2 == '0) ? P_W'(1) : p_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s3 <= '0;
		end else begin
			side_s3 <= side_s2;
		end
	end

	always_ff @(posedge clk) begin
		x_s3 <= XL_W'(pv) << (E_W'(FRAC) - side_s2.expo);
	end

	// ---- log cell row
	side_t            side_ln [CORDIC_STAGES+1];
	logic [XL_W-1:0]  x_ln [CORDIC_STAGES+1];
	logic [ACC_W-1:0] acc_ln [CORDIC_STAGES+1];

	assign side_ln[0] = side_s3;
	assign x_ln[0] = x_s3;
	assign acc_ln[0] = '0;

	for (genvar g = 1; g <= CORDIC_STAGES; g++) begin : g_ln
		bpa_ln_cell #(
			.SHIFT(g),
			.LNK(ACC_W'(lntab_f(g)))
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.side_in (side_ln[g-1]),
			.x_in    (x_ln[g-1]),
			.acc_in  (acc_ln[g-1]),
			.side_out(side_ln[g]),
			.x_out   (x_ln[g]),
			.acc_out (acc_ln[g])
		);
	end

	// ---- stage 4: ln(p) = e*ln2 + ln2 - acc - (2-x)/2
	side_t                   side_s4;
	logic signed [LNV_W-1:0] lnv_s4;
	logic [LNV_W-1:0]        lnv_pos;
	logic [LNV_W-1:0]        lnv_neg;

	assign lnv_pos = LNV_W'(side_ln[CORDIC_STAGES].expo) * LNV_W'(LN2Q) + LNV_W'(LN2Q);
	assign lnv_neg = LNV_W'(acc_ln[CORDIC_STAGES])
		+ LNV_W'((XL_W'(TWO_Q) - x_ln[CORDIC_STAGES]) >> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s4 <= '0;
		end else begin
			side_s4 <= side_ln[CORDIC_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		lnv_s4 <= $signed(lnv_pos) - $signed(lnv_neg);
	end

	// ---- stage 5: log ratio against layer base
	side_t                   side_c5;
	side_t                   side_s5;
	logic signed [LNV_W-1:0] lnr_w;

	assign lnr_w = lnv_s4 - $signed(LNV_W'(LN_PB[side_s4.layer]));

	always_comb begin
		side_c5 = side_s4;
		side_c5.lnr = lnr_w[LNR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s5 <= '0;
		end else begin
			side_s5 <= side_c5;
		end
	end

	// ---- stage 6: y = k * lnr, magnitude product
	logic [LNR_W-1:0]  lnr_abs;
	logic [PK_W-1:0]   prod_k_s6;
	logic              neg_k_s6;
	side_t             side_s6;

	assign lnr_abs = side_s5.lnr[LNR_W-1] ? $unsigned(-side_s5.lnr) : $unsigned(side_s5.lnr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s6 <= '0;
		end else begin
			side_s6 <= side_s5;
		end
	end

	always_ff @(posedge clk) begin
		prod_k_s6 <= PK_W'(KQ_W'(KQ_MAG[side_s5.layer])) * PK_W'(lnr_abs[LNR_W-2:0]);
		neg_k_s6 <= (KQ_NEG[side_s5.layer] != 0) ^ side_s5.lnr[LNR_W-1];
	end

	// ---- stage 7: round, saturate, bias into the exp residual
	logic [PK_W:0]  yr_sum;
	logic [R_W-1:0] ymag;
	logic [R_W-1:0] r_s7;
	side_t          side_s7;

	assign yr_sum = {1'b0, prod_k_s6} + ((PK_W+1)'(1) << (FRAC - 1));

	always_comb begin
		if (yr_sum[PK_W:FRAC] > (PK_W+1-FRAC)'(EXP_LIM_R)) begin
			ymag = EXP_LIM_R;
		end else begin
			ymag = R_W'(yr_sum[PK_W:FRAC]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s7 <= '0;
		end else begin
			side_s7 <= side_s6;
		end
	end

	always_ff @(posedge clk) begin
		r_s7 <= neg_k_s6 ? TWO_LN2 - ymag : TWO_LN2 + ymag;
	end

	// ---- exp cell row: two doubling cells, then one per table entry
	localparam int NE = CORDIC_STAGES + 2;

	side_t           side_ex [NE+1];
	logic [XE_W-1:0] x_ex [NE+1];
	logic [R_W-1:0]  r_ex [NE+1];

	assign side_ex[0] = side_s7;
	assign x_ex[0] = XE_W'(1) << (FRAC - 2);
	assign r_ex[0] = r_s7;

	for (genvar g = 0; g < NE; g++) begin : g_ex
		localparam int SH = (g < 2) ? 0 : g - 1;
		bpa_exp_cell #(
			.SHIFT(SH),
			.LNK(R_W'(lntab_f(SH)))
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.side_in (side_ex[g]),
			.x_in    (x_ex[g]),
			.r_in    (r_ex[g]),
			.side_out(side_ex[g+1]),
			.x_out   (x_ex[g+1]),
			.r_out   (r_ex[g+1])
		);
	end

	// ---- stage 8: residual correction product x*r
	side_t           side_s8;
	logic [XR_W-1:0] xr_s8;
	logic [XE_W-1:0] xe_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s8 <= '0;
		end else begin
			side_s8 <= side_ex[NE];
		end
	end

	always_ff @(posedge clk) begin
		xr_s8 <= XR_W'(x_ex[NE]) * XR_W'(r_ex[NE]);
		xe_s8 <= x_ex[NE];
	end

	// ---- stage 9: pick multiplicand: exp-1 for lapse layers, -lnr for isothermal
	logic [LNR_W-1:0]        ex_v;
	logic signed [LNR_W-1:0] em1;
	logic signed [LNR_W-1:0] b_s9;
	side_t                   side_s9;

	assign ex_v = LNR_W'(xe_s8) + LNR_W'(xr_s8 >> FRAC);
	assign em1 = $signed(ex_v) - $signed(LNR_W'(1) << FRAC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s9 <= '0;
		end else begin
			side_s9 <= side_s8;
		end
	end

	always_ff @(posedge clk) begin
		b_s9 <= (LAPSE_E4[side_s8.layer] != 0) ? em1 : -side_s8.lnr;
	end

	// ---- stage 10: coefficient product
	logic [LNR_W-1:0] b_abs;
	logic [PC_W-1:0]  prod_c_s10;
	logic             neg_c_s10;
	side_t            side_s10;

	assign b_abs = b_s9[LNR_W-1] ? $unsigned(-b_s9) : $unsigned(b_s9);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s10 <= '0;
		end else begin
			side_s10 <= side_s9;
		end
	end

	always_ff @(posedge clk) begin
		prod_c_s10 <= PC_W'(COEF_W'(COEF_MAG[side_s9.layer])) * PC_W'(b_abs[LNR_W-2:0]);
		neg_c_s10 <= (COEF_NEG[side_s9.layer] != 0) ^ b_s9[LNR_W-1];
	end

	// ---- stage 11: round Q38 product, add base height, saturate, register out
	logic [PC_W:0]          hc_sum;
	logic [HS_W-1:0]        hmag;
	logic signed [HS_W-1:0] h_raw;
	logic signed [HS_W-1:0] h_fin;
	logic                   done_q;
	logic signed [H_W-1:0]  altitude_q;
	status_t                status_q;

	assign hc_sum = {1'b0, prod_c_s10} + ((PC_W+1)'(1) << (FRAC + 9));
	assign hmag = HS_W'(hc_sum >> (FRAC + 10));
	assign h_raw = $signed(HS_W'(BASE_M[side_s10.layer] * 16))
		+ (neg_c_s10 ? -$signed(hmag) : $signed(hmag));

	always_comb begin
		case (side_s10.status)
			ST_CLAMP_LO: h_fin = LO_H;
			ST_CLAMP_HI: h_fin = HI_H;
			default: begin
				if (h_raw < LO_H) begin
					h_fin = LO_H;
				end else if (h_raw > HI_H) begin
					h_fin = HI_H;
				end else begin
					h_fin = h_raw;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= side_s10.valid;
		end
	end

	always_ff @(posedge clk) begin
		altitude_q <= h_fin[H_W-1:0];
		status_q <= side_s10.status;
	end

	assign done = done_q;
	assign altitude = altitude_q;
	assign range_status = status_q;

	// ---- checks
	`BPA_CHECK_LAT(a_fixed_latency, clk, arst_n, start, LAT, done, "result beat missing after start")
	`BPA_CHECK(a_clamp_lo, clk, arst_n, done && range_status == ST_CLAMP_LO, altitude == LO_H[H_W-1:0], "bottom clamp height wrong")
	`BPA_CHECK(a_clamp_hi, clk, arst_n, done && range_status == ST_CLAMP_HI, altitude == HI_H[H_W-1:0], "top clamp height wrong")
	`BPA_CHECK(a_in_bounds, clk, arst_n, done, altitude >= $signed(LO_H[H_W-1:0]) && altitude <= $signed(HI_H[H_W-1:0]), "height outside base heights")

endmodule

// ===== dv/barometric_pressure_to_altitude_tb.sv =====
// Self-checking testbench for the pressure-to-altitude converter.
module barometric_pressure_to_altitude_tb;
	import bpa_pkg::*;

	localparam int LAYERS = NUM_LAYERS_DEF;
	localparam int STAGES = CORDIC_STAGES_DEF;
	localparam int DRAIN_CYCLES = 2 * STAGES + 40; // pipeline depth plus margin
	localparam int CYCLE_LIMIT = 200000;
	localparam longint unsigned ONE_Q = 64'd1 << 28;
	localparam longint unsigned TWO_Q_TB = 64'd2 << 28;
	localparam longint unsigned P_MAX = (64'd1 << P_W) - 1;

	typedef struct {
		logic signed [H_W-1:0] alt;
		status_t               st;
	} height_t;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [P_W-1:0]        pressure;
	logic                  done;
	logic signed [H_W-1:0] altitude;
	logic [1:0]            range_status;

	// atmosphere description: base heights (m) and lapse rates (1e-4 K/m)
	longint base_h [8] = '{-610, 11000, 20000, 32000, 47000, 51000, 71000, 84852};
	longint lapse [8] = '{-65, 0, 10, 28, 0, -28, -20, 0};

	// derived layer constants
	longint unsigned ln_step [STAGES+1];
	longint ln_two;
	longint ln_base_p [8];
	longint unsigned base_p [8];
	longint exp_k [8];
	longint h_coef [8];

	logic [P_W-1:0] pending_p [$];
	height_t heights_due [$];
	int fails;
	int cycles;
	int gap_left;
	int burst_left;

	barometric_pressure_to_altitude u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.pressure(pressure),
		.done(done),
		.altitude(altitude),
		.range_status(range_status)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// long division with fb extra fraction bits, truncating
	function automatic longint unsigned frac_div(longint unsigned n, longint unsigned d, int fb);
		longint unsigned q;
		longint unsigned r;
		if (d == 0) return 0;
		q = n / d;
		r = n % d;
		for (int i = 0; i < fb; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= d) begin
				r = r - d;
				q = q | 64'd1;
			end
		end
		return q;
	endfunction

	function automatic longint unsigned absval(longint a);
		return (a < 0) ? longint'(-a) : longint'(a);
	endfunction

	// signed product, rounded half away from zero
	function automatic longint mul_rnd(longint a, longint b, int sh);
		longint unsigned p;
		p = absval(a) * absval(b);
		p = (p + (64'd1 << (sh - 1))) >> sh;
		return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
	endfunction

	// natural log in Q28 by multiplicative normalization
	function automatic longint ln_q28(longint unsigned v);
		int e;
		longint unsigned x;
		longint unsigned t;
		longint unsigned acc;
		if (v == 0) v = 1;
		e = 0;
		while (e < 63 && (v >> (e + 1)) != 0) e++;
		x = (e <= 28) ? (v << (28 - e)) : (v >> (e - 28));
		acc = 0;
		for (int i = 1; i <= STAGES; i++) begin
			t = x + (x >> i);
			if (t < TWO_Q_TB) begin
				x = t;
				acc = acc + ln_step[i];
			end
		end
		return longint'(e) * ln_two + ln_two - longint'(acc) - longint'((TWO_Q_TB - x) >> 1);
	endfunction

	// exp in Q28, argument clamped to +-0.75
	function automatic longint unsigned exp_q28(longint y);
		longint unsigned x;
		longint unsigned r;
		if (y > 64'sd201326592) y = 64'sd201326592;
		if (y < -64'sd201326592) y = -64'sd201326592;
		r = longint'(y + 2 * ln_two);
		x = ONE_Q >> 2;
		for (int i = 0; i < 2; i++)
			if (r >= ln_step[0]) begin
				r = r - ln_step[0];
				x = x << 1;
			end
		for (int i = 1; i <= STAGES; i++)
			if (r >= ln_step[i]) begin
				r = r - ln_step[i];
				x = x + (x >> i);
			end
		return x + ((x * r) >> 28);
	endfunction

	// layer recursion: base pressures, their logs and the height coefficients
	task automatic derive_layers();
		longint temp [8];
		longint unsigned u;
		longint unsigned u2;
		longint unsigned pw;
		longint unsigned s;
		longint lr;
		longint dh;
		longint dlt;
		longint ex;
		longint n;
		longint unsigned x;
		for (int i = 0; i <= STAGES; i++) begin
			u = frac_div(1, (64'd1 << (i + 1)) + 1, 31);
			u2 = (u * u) >> 31;
			pw = u;
			s = u;
			for (int k = 1; k <= 12; k++) begin
				pw = (pw * u2) >> 31;
				s = s + pw / longint'(2 * k + 1);
			end
			ln_step[i] = (2 * s + 4) >> 3;
		end
		ln_two = longint'(ln_step[0]);
		temp[0] = 2921500;
		base_p[0] = 1089000;
		ln_base_p[0] = ln_q28(1089000);
		for (int i = 1; i < 8; i++) begin
			lr = lapse[i-1];
			dh = base_h[i] - base_h[i-1];
			if (dh < 0) dh = 0;
			temp[i] = temp[i-1] + lr * dh;
			if (temp[i] < 1) temp[i] = 1;
			if (lr != 0) begin
				dlt = ln_q28(temp[i-1]) - ln_q28(temp[i]);
				ex = longint'(frac_div(64'd980665 * 64'd10000, 64'd28705287 * absval(lr), 20));
				if (lr < 0) ex = -ex;
				ln_base_p[i] = ln_base_p[i-1] + mul_rnd(ex, dlt, 20);
			end else begin
				ln_base_p[i] = ln_base_p[i-1] - longint'(frac_div(
					64'd980665 * 64'd10000 * longint'(dh), 64'd28705287 * longint'(temp[i-1]), 28));
			end
			if (ln_base_p[i] < 0) ln_base_p[i] = 0;
			n = ln_base_p[i] / ln_two;
			if (n > 30) n = 30;
			x = exp_q28(ln_base_p[i] - n * ln_two);
			base_p[i] = ((x << n) + (ONE_Q >> 1)) >> 28;
		end
		for (int i = 0; i < 8; i++) begin
			lr = lapse[i];
			if (lr != 0) begin
				exp_k[i] = longint'(frac_div(64'd28705287 * absval(lr), 64'd980665 * 64'd10000, 28));
				h_coef[i] = longint'(frac_div(longint'(temp[i]) * 16, absval(lr), 10));
				if (lr < 0) h_coef[i] = -h_coef[i];
				else exp_k[i] = -exp_k[i];
			end else begin
				exp_k[i] = 0;
				h_coef[i] = longint'(frac_div(64'd28705287 * longint'(temp[i]) * 16,
					64'd980665 * 64'd10000, 10));
			end
		end
	endtask

	function automatic height_t predict_height(logic [P_W-1:0] p_in);
		height_t res;
		longint unsigned p;
		longint h;
		longint lo;
		longint hi;
		longint lnr;
		longint y;
		int j;
		p = 64'(p_in);
		lo = base_h[0] * 16;
		hi = base_h[LAYERS-1] * 16;
		res.st = ST_IN_RANGE;
		if (p > base_p[0]) begin
			h = lo;
			res.st = ST_CLAMP_LO;
		end else if (p < base_p[LAYERS-1]) begin
			h = hi;
			res.st = ST_CLAMP_HI;
		end else begin
			// first layer whose base is at or below p; equal to a base picks the lower layer
			j = LAYERS - 2;
			for (int i = LAYERS - 1; i >= 1; i--)
				if (base_p[i] <= p) j = i - 1;
			lnr = ln_q28(p) - ln_base_p[j];
			h = base_h[j] * 16;
			if (lapse[j] != 0) begin
				y = mul_rnd(exp_k[j], lnr, 28);
				h = h + mul_rnd(h_coef[j], longint'(exp_q28(y)) - longint'(ONE_Q), 38);
			end else begin
				h = h - mul_rnd(h_coef[j], lnr, 38);
			end
			if (h < lo) h = lo;
			if (h > hi) h = hi;
		end
		res.alt = h[H_W-1:0];
		return res;
	endfunction

	// driver: bursts of beats with random gaps, sometimes long runs with no gap
	always @(negedge clk) begin
		if (!arst_n || pending_p.size() == 0) begin
			start <= 1'b0;
		end else if (gap_left > 0) begin
			gap_left <= gap_left - 1;
			start <= 1'b0;
		end else begin
			start <= 1'b1;
			pressure <= pending_p[0];
			if (burst_left <= 1) begin
				burst_left <= $urandom_range(1, 30);
				gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			end else begin
				burst_left <= burst_left - 1;
			end
		end
	end

	// monitor: accept beats, predict, check results
	always @(posedge clk) begin
		height_t want;
		if (arst_n) begin
			if (start && !busy) begin
				heights_due.push_back(predict_height(pressure));
				void'(pending_p.pop_front());
			end
			if (done) begin
				if (heights_due.size() == 0) begin
					$error("result with nothing pending: altitude %0d status %0d",
						altitude, range_status);
					fails++;
				end else begin
					want = heights_due.pop_front();
					if (altitude !== want.alt) begin
						$error("altitude expected %0d actual %0d", want.alt, altitude);
						fails++;
					end
					if (range_status !== want.st) begin
						$error("range_status expected %0d actual %0d", want.st, range_status);
						fails++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("barometric_pressure_to_altitude: mismatch");
			$finish;
		end
	end

	initial begin
		int lyr;
		longint unsigned a;
		longint unsigned b;
		start = 1'b0;
		pressure = '0;
		arst_n = 1'b0;
		fails = 0;
		cycles = 0;
		gap_left = 0;
		burst_left = 5;
		derive_layers();

		// directed: field extremes, layer bases and their neighbors
		pending_p.push_back(P_W'(0));
		pending_p.push_back(P_W'(1));
		pending_p.push_back(P_MAX[P_W-1:0]);
		for (int i = 0; i < LAYERS; i++) begin
			pending_p.push_back(P_W'(base_p[i]));
			pending_p.push_back(P_W'(base_p[i] + 1));
			if (base_p[i] > 0) pending_p.push_back(P_W'(base_p[i] - 1));
		end

		// random: mostly in-range samples spread over every layer
		for (int n = 0; n < 450; n++) begin
			case ($urandom_range(0, 9))
				0, 1: pending_p.push_back(P_W'($urandom_range(0, 32'(P_MAX))));
				2: begin
					lyr = $urandom_range(0, LAYERS - 1);
					pending_p.push_back(P_W'(base_p[lyr] + $urandom_range(0, 8) - 4));
				end
				default: begin
					lyr = $urandom_range(0, LAYERS - 2);
					a = base_p[lyr + 1];
					b = base_p[lyr];
					pending_p.push_back(P_W'($urandom_range(32'(a), 32'(b))));
				end
			endcase
		end

		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		wait (pending_p.size() == 0 && heights_due.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0) begin
			$display("barometric_pressure_to_altitude: match");
		end else begin
			$display("barometric_pressure_to_altitude: mismatch");
		end
		$finish;
	end

endmodule

// ===== barometric_pressure_to_altitude.f =====
+incdir+rtl
rtl/bpa_pkg.sv
rtl/bpa_ln_cell.sv
rtl/bpa_exp_cell.sv
rtl/barometric_pressure_to_altitude.sv
dv/barometric_pressure_to_altitude_tb.sv
